// ===== rtl/dde_pkg.sv =====
// Shared types, constants and helpers for the odometry EKF predict block.
// No dependencies; every other rtl file imports it.
package dde_pkg;

   localparam int WORD_W    = 48;
   localparam int OPND_W    = 49;
   localparam int TICK_MAX  = 32;
   localparam int NUM_WORDS = 12;
   localparam int CSR_IDX_W = 8;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [OPND_W-1:0] opnd_type;
   typedef logic signed [33:0]       cordic_type;

   localparam word_type MAX48 = {1'b0, {(WORD_W-1){1'b1}}};
   localparam word_type MIN48 = {1'b1, {(WORD_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_DIST_PER_TICK     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_TRACK         = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_VARIANCE = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_VARIANCE  = 8'd3;

   localparam opnd_type   INV_TWO_PI   = 49'sd683565276;
   localparam cordic_type CORDIC_GAIN  = 34'sd652032875;
   localparam logic [4:0] CORDIC_LAST  = 5'd23;

   typedef enum logic [1:0] {
      ITEM_LOAD,
      ITEM_EMIT,
      ITEM_PREDICT
   } item_kind_type;

   typedef struct packed {
      item_kind_type            kind;
      logic [3:0]               load_index;
      word_type                 load_value;
      logic signed [TICK_MAX-1:0] dl;
      logic signed [TICK_MAX-1:0] dr;
   } item_type;

   typedef enum logic [1:0] {
      SH_0,
      SH_16,
      SH_30,
      SH_32
   } shift_type;

   typedef struct packed {
      logic      start;
      opnd_type  a;
      opnd_type  b;
      shift_type sh;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      word_type    res;
      logic [31:0] phase;
   } mul_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_WAIT,
      BK_CORDIC,
      BK_OUT
   } back_state_type;

   typedef enum logic [4:0] {
      OP_LEFT, OP_RIGHT, OP_PHASE, OP_DX, OP_DY, OP_TURN,
      OP_A0, OP_A1, OP_A2, OP_A3, OP_A4, OP_A5,
      OP_M0, OP_M1, OP_M3, OP_M4, OP_M6, OP_M7,
      OP_CC, OP_VCC, OP_CS, OP_VCS, OP_SS, OP_VSS
   } step_type;

   function automatic word_type sat_add48(word_type a, word_type b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         return s[WORD_W] ? MIN48 : MAX48;
      end
      return s[WORD_W-1:0];
   endfunction

   function automatic word_type neg_sat48(word_type v);
      if (v == MIN48) begin
         return MAX48;
      end
      return -v;
   endfunction

   // atan(2^-i) in turns, 2^32 per turn
   function automatic logic [31:0] turn_angle(logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051D;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/dde_front.sv =====
// Front end: accepts request words, tracks previous encoder counts and
// classifies each word for the back end. Depends on dde_pkg.
module dde_front import dde_pkg::*; #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_func,
   input  logic signed [31:0]      req_left_ticks,
   input  logic signed [31:0]      req_right_ticks,
   input  logic [3:0]              req_load_index,
   input  logic signed [47:0]      req_load_value,
   output logic                    push_valid,
   input  logic                    push_ready,
   output item_type                push_item
);

   logic [TICK_WIDTH-1:0] prev_l_ff, prev_l_in;
   logic [TICK_WIDTH-1:0] prev_r_ff, prev_r_in;
   logic                  seen_ff, seen_in;
   logic [TICK_WIDTH-1:0] left, right;
   logic signed [TICK_WIDTH-1:0] dl_s, dr_s;
   logic                  accept;

   assign left      = req_left_ticks[TICK_WIDTH-1:0];
   assign right     = req_right_ticks[TICK_WIDTH-1:0];
   assign dl_s      = signed'(left - prev_l_ff);
   assign dr_s      = signed'(right - prev_r_ff);
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   // the first encoder word only primes the counts
   assign push_valid = req_valid && (req_func || seen_ff);

   always_comb begin
      push_item.load_index = req_load_index;
      push_item.load_value = req_load_value;
      push_item.dl         = TICK_MAX'(dl_s);
      push_item.dr         = TICK_MAX'(dr_s);
      if (req_func) begin
         push_item.kind = ITEM_LOAD;
      end else if (left != prev_l_ff || right != prev_r_ff) begin
         push_item.kind = ITEM_PREDICT;
      end else begin
         push_item.kind = ITEM_EMIT;
      end
      prev_l_in = prev_l_ff;
      prev_r_in = prev_r_ff;
      seen_in   = seen_ff;
      if (accept && !req_func) begin
         prev_l_in = left;
         prev_r_in = right;
         seen_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_l_ff <= '0;
         prev_r_ff <= '0;
         seen_ff   <= 1'b0;
      end else begin
         prev_l_ff <= prev_l_in;
         prev_r_ff <= prev_r_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

// ===== rtl/dde_queue.sv =====
// Two-entry word queue between front and back end.
// Depends on dde_pkg for the item type.
module dde_queue import dde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ===== rtl/dde_mul.sv =====
// Shared multi-cycle signed 49x49 multiplier: four 25x25 partial products,
// then round-half-away, shift and saturate to 48 bits. Depends on dde_pkg.
module dde_mul import dde_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp,
   output logic        mul_busy
);

   logic        run_ff;
   logic [2:0]  k_ff;
   logic [48:0] ma_ff, mb_ff;
   logic        neg_ff;
   shift_type   sh_ff;
   logic [97:0] acc_ff;
   logic        done_ff;
   word_type    res_ff;
   logic [31:0] phase_ff;

   logic [24:0] pa, pb;
   logic [49:0] pp;
   logic [97:0] term, shifted;
   logic [63:0] raw;
   logic        big;
   word_type    res_in;

   assign pa = k_ff[1] ? {1'b0, ma_ff[48:25]} : ma_ff[24:0];
   assign pb = k_ff[0] ? {1'b0, mb_ff[48:25]} : mb_ff[24:0];
   assign pp = pa * pb;

   always_comb begin
      case (k_ff[1:0])
         2'd0:    term = {48'b0, pp};
         2'd3:    term = {48'b0, pp} << 50;
         default: term = {48'b0, pp} << 25;
      endcase
      case (sh_ff)
         SH_16:   shifted = (acc_ff + (98'd1 << 15)) >> 16;
         SH_30:   shifted = (acc_ff + (98'd1 << 29)) >> 30;
         SH_32:   shifted = (acc_ff + (98'd1 << 31)) >> 32;
         default: shifted = acc_ff;
      endcase
      big = |shifted[97:48];
      if (neg_ff) begin
         res_in = (big || shifted[47:0] > {1'b1, 47'b0}) ? MIN48 : -signed'(shifted[47:0]);
      end else begin
         res_in = (big || shifted[47]) ? MAX48 : signed'(shifted[47:0]);
      end
      // low word of the exact signed product, used for the heading phase
      raw = neg_ff ? (~acc_ff[63:0] + 64'd1) : acc_ff[63:0];
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         ma_ff  <= mul_req.a[48] ? 49'(~mul_req.a + 49'sd1) : 49'(mul_req.a);
         mb_ff  <= mul_req.b[48] ? 49'(~mul_req.b + 49'sd1) : 49'(mul_req.b);
         neg_ff <= mul_req.a[48] ^ mul_req.b[48];
         sh_ff  <= mul_req.sh;
         acc_ff <= '0;
      end else if (run_ff && !k_ff[2]) begin
         acc_ff <= acc_ff + term;
      end
      if (run_ff && k_ff[2]) begin
         res_ff   <= res_in;
         phase_ff <= raw[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         k_ff    <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && k_ff[2];
         if (mul_req.start) begin
            run_ff <= 1'b1;
            k_ff   <= 3'd0;
         end else if (run_ff) begin
            if (k_ff[2]) begin
               run_ff <= 1'b0;
            end else begin
               k_ff <= k_ff + 3'd1;
            end
         end
      end
   end

   assign mul_busy      = run_ff;
   assign mul_rsp.done  = done_ff;
   assign mul_rsp.res   = res_ff;
   assign mul_rsp.phase = phase_ff;

endmodule

// ===== rtl/dde_back.sv =====
// Back end: sequences the predict step over the shared multiplier and an
// iterative CORDIC, holds pose/covariance and the result register. Depends on dde_pkg.
module dde_back import dde_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  item_type                     pop_item,
   input  logic [31:0]                  dist_per_tick,
   input  logic [31:0]                  inv_track,
   input  logic [31:0]                  distance_variance,
   input  logic [31:0]                  heading_variance,
   output mul_req_type                  mul_req,
   input  mul_rsp_type                  mul_rsp,
   input  logic                         mul_busy,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [NUM_WORDS-1:0][47:0]   rsp_words
);

   back_state_type state_ff, state_in;
   step_type       op_ff;
   word_type       st_ff [NUM_WORDS];
   logic [NUM_WORDS-1:0][47:0] out_ff;
   logic           rsp_valid_ff;
   word_type       ld_ff, rd_ff, dx_ff, dy_ff, t_ff;
   logic signed [TICK_MAX-1:0] dl_ff, dr_ff;
   cordic_type     c_ff, s_ff, cx_ff, cy_ff, cz_ff;
   logic [4:0]     it_ff;
   logic           flip_ff;

   logic           out_load;
   logic signed [48:0] dsum, dhalf, diff;
   word_type       d, fa, fb;
   logic [3:0]     dst_a, dst_b;
   logic           dst_a_en, dst_b_en, to_t, add_vh;
   cordic_type     tx, ty, ang, cx_nx, cy_nx, cz_nx;
   logic [31:0]    ph;
   logic           flip_in;

   assign dsum  = {ld_ff[47], ld_ff} + {rd_ff[47], rd_ff};
   // halve toward zero
   assign dhalf = (dsum >>> 1) + $signed(49'(dsum[48] & dsum[0]));
   assign d     = dhalf[47:0];
   assign diff  = {rd_ff[47], rd_ff} - {ld_ff[47], ld_ff};
   assign fa    = neg_sat48(dy_ff);
   assign fb    = dx_ff;

   always_comb begin
      mul_req.start = (state_ff == BK_MUL);
      mul_req.a  = '0;
      mul_req.b  = '0;
      mul_req.sh = SH_32;
      dst_a      = '0;
      dst_a_en   = 1'b0;
      dst_b      = 4'd6;
      dst_b_en   = 1'b0;
      to_t       = 1'b0;
      add_vh     = 1'b0;
      unique case (op_ff)
         OP_LEFT:  begin mul_req.a = 49'(dl_ff); mul_req.b = {17'b0, dist_per_tick};
                   mul_req.sh = SH_0; end
         OP_RIGHT: begin mul_req.a = 49'(dr_ff); mul_req.b = {17'b0, dist_per_tick};
                   mul_req.sh = SH_0; end
         OP_PHASE: begin mul_req.a = 49'(st_ff[2]); mul_req.b = INV_TWO_PI;
                   mul_req.sh = SH_0; end
         OP_DX:    begin mul_req.a = 49'(d); mul_req.b = 49'(c_ff); mul_req.sh = SH_30;
                   dst_a = 4'd0; dst_a_en = 1'b1; end
         OP_DY:    begin mul_req.a = 49'(d); mul_req.b = 49'(s_ff); mul_req.sh = SH_30;
                   dst_a = 4'd1; dst_a_en = 1'b1; end
         OP_TURN:  begin mul_req.a = diff; mul_req.b = {17'b0, inv_track};
                   mul_req.sh = SH_16; dst_a = 4'd2; dst_a_en = 1'b1; end
         OP_A0:    begin mul_req.a = 49'(fa); mul_req.b = 49'(st_ff[9]);
                   dst_a = 4'd3; dst_a_en = 1'b1; end
         OP_A1:    begin mul_req.a = 49'(fa); mul_req.b = 49'(st_ff[10]);
                   dst_a = 4'd4; dst_a_en = 1'b1; end
         OP_A2:    begin mul_req.a = 49'(fa); mul_req.b = 49'(st_ff[11]);
                   dst_a = 4'd5; dst_a_en = 1'b1; end
         OP_A3:    begin mul_req.a = 49'(fb); mul_req.b = 49'(st_ff[9]);
                   dst_a = 4'd6; dst_a_en = 1'b1; end
         OP_A4:    begin mul_req.a = 49'(fb); mul_req.b = 49'(st_ff[10]);
                   dst_a = 4'd7; dst_a_en = 1'b1; end
         OP_A5:    begin mul_req.a = 49'(fb); mul_req.b = 49'(st_ff[11]);
                   dst_a = 4'd8; dst_a_en = 1'b1; end
         OP_M0:    begin mul_req.a = 49'(fa); mul_req.b = 49'(st_ff[5]);
                   dst_a = 4'd3; dst_a_en = 1'b1; end
         OP_M1:    begin mul_req.a = 49'(fb); mul_req.b = 49'(st_ff[5]);
                   dst_a = 4'd4; dst_a_en = 1'b1; end
         OP_M3:    begin mul_req.a = 49'(fa); mul_req.b = 49'(st_ff[8]);
                   dst_a = 4'd6; dst_a_en = 1'b1; end
         OP_M4:    begin mul_req.a = 49'(fb); mul_req.b = 49'(st_ff[8]);
                   dst_a = 4'd7; dst_a_en = 1'b1; end
         OP_M6:    begin mul_req.a = 49'(fa); mul_req.b = 49'(st_ff[11]);
                   dst_a = 4'd9; dst_a_en = 1'b1; end
         OP_M7:    begin mul_req.a = 49'(fb); mul_req.b = 49'(st_ff[11]);
                   dst_a = 4'd10; dst_a_en = 1'b1; end
         OP_CC:    begin mul_req.a = 49'(c_ff); mul_req.b = 49'(c_ff);
                   mul_req.sh = SH_30; to_t = 1'b1; end
         OP_VCC:   begin mul_req.a = 49'(t_ff); mul_req.b = {17'b0, distance_variance};
                   mul_req.sh = SH_30; dst_a = 4'd3; dst_a_en = 1'b1; end
         OP_CS:    begin mul_req.a = 49'(c_ff); mul_req.b = 49'(s_ff);
                   mul_req.sh = SH_30; to_t = 1'b1; end
         OP_VCS:   begin mul_req.a = 49'(t_ff); mul_req.b = {17'b0, distance_variance};
                   mul_req.sh = SH_30; dst_a = 4'd4; dst_a_en = 1'b1;
                   dst_b_en = 1'b1; end
         OP_SS:    begin mul_req.a = 49'(s_ff); mul_req.b = 49'(s_ff);
                   mul_req.sh = SH_30; to_t = 1'b1; end
         OP_VSS:   begin mul_req.a = 49'(t_ff); mul_req.b = {17'b0, distance_variance};
                   mul_req.sh = SH_30; dst_a = 4'd7; dst_a_en = 1'b1;
                   add_vh = 1'b1; end
         default:  begin end
      endcase
   end

   // one CORDIC rotation per cycle
   always_comb begin
      tx  = cy_ff >>> it_ff;
      ty  = cx_ff >>> it_ff;
      ang = {2'b0, turn_angle(it_ff)};
      if (!cz_ff[33]) begin
         cx_nx = cx_ff - tx;
         cy_nx = cy_ff + ty;
         cz_nx = cz_ff - ang;
      end else begin
         cx_nx = cx_ff + tx;
         cy_nx = cy_ff - ty;
         cz_nx = cz_ff + ang;
      end
      // phases in the left half plane are rotated by half a turn
      flip_in = (mul_rsp.phase[31:30] == 2'd1) || (mul_rsp.phase[31:30] == 2'd2);
      ph      = flip_in ? (mul_rsp.phase ^ 32'h80000000) : mul_rsp.phase;
   end

   always_comb begin
      state_in      = state_ff;
      pop_ready     = 1'b0;
      out_load      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               unique case (pop_item.kind)
                  ITEM_EMIT:    state_in = BK_OUT;
                  ITEM_PREDICT: state_in = BK_MUL;
                  default:      state_in = BK_IDLE;
               endcase
            end
         end
         BK_MUL: begin
            state_in      = BK_WAIT;
         end
         BK_WAIT: begin
            if (mul_rsp.done) begin
               if (op_ff == OP_PHASE) begin
                  state_in = BK_CORDIC;
               end else if (op_ff == OP_VSS) begin
                  state_in = BK_OUT;
               end else begin
                  state_in = BK_MUL;
               end
            end
         end
         BK_CORDIC: begin
            if (it_ff == CORDIC_LAST) state_in = BK_MUL;
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_WORDS; k++) st_ff[k] <= '0;
      end else if (state_ff == BK_IDLE && pop_valid && pop_item.kind == ITEM_LOAD) begin
         for (int k = 0; k < NUM_WORDS; k++) begin
            if (pop_item.load_index == 4'(k)) st_ff[k] <= pop_item.load_value;
         end
      end else if (state_ff == BK_WAIT && mul_rsp.done) begin
         for (int k = 0; k < NUM_WORDS; k++) begin
            if (dst_a_en && dst_a == 4'(k)) begin
               st_ff[k] <= sat_add48(st_ff[k], mul_rsp.res);
            end else if (dst_b_en && dst_b == 4'(k)) begin
               st_ff[k] <= sat_add48(st_ff[k], mul_rsp.res);
            end else if (add_vh && k == NUM_WORDS - 1) begin
               st_ff[k] <= sat_add48(st_ff[k], {16'b0, heading_variance});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && pop_valid) begin
         dl_ff <= pop_item.dl;
         dr_ff <= pop_item.dr;
         op_ff <= OP_LEFT;
      end
      if (state_ff == BK_WAIT && mul_rsp.done) begin
         if (op_ff != OP_VSS) op_ff <= step_type'(op_ff + 5'd1);
         if (op_ff == OP_LEFT)  ld_ff <= mul_rsp.res;
         if (op_ff == OP_RIGHT) rd_ff <= mul_rsp.res;
         if (op_ff == OP_DX)    dx_ff <= mul_rsp.res;
         if (op_ff == OP_DY)    dy_ff <= mul_rsp.res;
         if (to_t)              t_ff  <= mul_rsp.res;
         if (op_ff == OP_PHASE) begin
            cx_ff   <= CORDIC_GAIN;
            cy_ff   <= '0;
            cz_ff   <= 34'(signed'(ph));
            it_ff   <= 5'd0;
            flip_ff <= flip_in;
         end
      end
      if (state_ff == BK_CORDIC) begin
         cx_ff <= cx_nx;
         cy_ff <= cy_nx;
         cz_ff <= cz_nx;
         it_ff <= it_ff + 5'd1;
         if (it_ff == CORDIC_LAST) begin
            c_ff <= flip_ff ? -cx_nx : cx_nx;
            s_ff <= flip_ff ? -cy_nx : cy_nx;
         end
      end
      if (out_load) begin
         for (int k = 0; k < NUM_WORDS; k++) out_ff[k] <= st_ff[k];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_words = out_ff;

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !mul_busy) else $error("multiply issued while busy");
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == BK_WAIT) else $error("stray multiply result");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff) else $error("result word not presented");
   a_cordic_it: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_CORDIC |-> it_ff <= CORDIC_LAST) else $error("CORDIC overrun");

endmodule

// ===== rtl/diff_drive_odometry_ekf_predict.sv =====
// Differential-drive odometry EKF predict block. A load word is written into
// the state by the back end while idle; an encoder word with unchanged counts
// returns the state through the queue, the BK_OUT state and the output
// register; a changed pair runs 24 products through the one shared 49x49
// multiplier (four 25x25 partial products each) plus 24 CORDIC rotations.
// The first encoder word only primes the counts and returns nothing. A two-word
// queue lets the front accept while the back end works. Depends on dde_pkg.
module diff_drive_odometry_ekf_predict import dde_pkg::*; #(
   parameter int TICK_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_func,
   input  logic signed [31:0]   req_left_ticks,
   input  logic signed [31:0]   req_right_ticks,
   input  logic [3:0]           req_load_index,
   input  logic signed [47:0]   req_load_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [47:0]   rsp_pose_x,
   output logic signed [47:0]   rsp_pose_y,
   output logic signed [47:0]   rsp_pose_heading,
   output logic signed [47:0]   rsp_cov_00,
   output logic signed [47:0]   rsp_cov_01,
   output logic signed [47:0]   rsp_cov_02,
   output logic signed [47:0]   rsp_cov_10,
   output logic signed [47:0]   rsp_cov_11,
   output logic signed [47:0]   rsp_cov_12,
   output logic signed [47:0]   rsp_cov_20,
   output logic signed [47:0]   rsp_cov_21,
   output logic signed [47:0]   rsp_cov_22,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   logic [31:0] mpt_ff, tinv_ff, dvar_ff, hvar_ff;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   item_type    push_item, pop_item;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   logic        mul_busy;
   logic [NUM_WORDS-1:0][47:0] words;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mpt_ff  <= '0;
         tinv_ff <= '0;
         dvar_ff <= '0;
         hvar_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DIST_PER_TICK:     mpt_ff  <= csr_wdata;
            CSR_INV_TRACK:         tinv_ff <= csr_wdata;
            CSR_DISTANCE_VARIANCE: dvar_ff <= csr_wdata;
            CSR_HEADING_VARIANCE:  hvar_ff <= csr_wdata;
            default: begin end
         endcase
      end
   end

   dde_front #(.TICK_WIDTH(TICK_WIDTH)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_left_ticks,
      .req_right_ticks, .req_load_index, .req_load_value,
      .push_valid, .push_ready, .push_item
   );

   dde_queue u_queue (
      .clock, .reset, .push_valid, .push_ready, .push_item,
      .pop_valid, .pop_ready, .pop_item
   );

   dde_mul u_mul (
      .clock, .reset, .mul_req, .mul_rsp, .mul_busy
   );

   dde_back u_back (
      .clock, .reset, .pop_valid, .pop_ready, .pop_item,
      .dist_per_tick(mpt_ff), .inv_track(tinv_ff),
      .distance_variance(dvar_ff), .heading_variance(hvar_ff),
      .mul_req, .mul_rsp, .mul_busy, .rsp_valid, .rsp_ready, .rsp_words(words)
   );

   assign rsp_pose_x       = words[0];
   assign rsp_pose_y       = words[1];
   assign rsp_pose_heading = words[2];
   assign rsp_cov_00       = words[3];
   assign rsp_cov_01       = words[4];
   assign rsp_cov_02       = words[5];
   assign rsp_cov_10       = words[6];
   assign rsp_cov_11       = words[7];
   assign rsp_cov_12       = words[8];
   assign rsp_cov_20       = words[9];
   assign rsp_cov_21       = words[10];
   assign rsp_cov_22       = words[11];

endmodule

// ===== sim/tb_diff_drive_odometry_ekf_predict.sv =====
// Testbench for diff_drive_odometry_ekf_predict: directed table, then random phases
// under several register settings, all checked against a local fixed-point predictor.
// Depends on rtl/dde_pkg.sv and rtl/diff_drive_odometry_ekf_predict.sv.
`timescale 1ns / 100ps

module tb_diff_drive_odometry_ekf_predict;
   import dde_pkg::*;

   localparam int DRAIN_CYCLES = 300;
   localparam longint SAT_HI = (64'sd1 <<< 47) - 1;
   localparam longint SAT_LO = -(64'sd1 <<< 47);

   typedef logic [11:0][47:0] state_snap_type;

   typedef enum logic {ROW_CSR, ROW_WORD} row_kind_type;

   typedef struct {
      row_kind_type                kind;
      logic                        func;
      logic [31:0]                 left;
      logic [31:0]                 right;
      logic [3:0]                  idx;
      logic [47:0]                 value;
      logic [CSR_IDX_W-1:0]        reg_idx;
      logic [31:0]                 reg_data;
      bit                          zero_state;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = 1'b0;
   logic signed [31:0] req_left_ticks = '0;
   logic signed [31:0] req_right_ticks = '0;
   logic [3:0] req_load_index = '0;
   logic signed [47:0] req_load_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [47:0] rsp_pose_x, rsp_pose_y, rsp_pose_heading;
   logic signed [47:0] rsp_cov_00, rsp_cov_01, rsp_cov_02, rsp_cov_10, rsp_cov_11;
   logic signed [47:0] rsp_cov_12, rsp_cov_20, rsp_cov_21, rsp_cov_22;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   diff_drive_odometry_ekf_predict dut (.*);

   always #5 clock = ~clock;

   // predictor state
   longint unsigned gain_mpt, gain_track, var_dist, var_head;
   longint pose_m [3];
   longint cov_m [9];
   logic [31:0] last_left, last_right;
   bit primed;

   localparam logic [31:0] ATAN_TURNS [24] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

   state_snap_type pending_states[$];
   int errors = 0;
   int states_checked = 0;
   int words_sent = 0;
   int tx_idle_pct = 0, rx_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   string field_names [12] = '{"pose_x", "pose_y", "pose_heading", "cov_00", "cov_01",
      "cov_02", "cov_10", "cov_11", "cov_12", "cov_20", "cov_21", "cov_22"};

   function automatic longint clip48(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // (a*b) >> sh, round half away from zero, clipped to 48 bits
   function automatic longint mul_round(longint a, longint b, int sh);
      logic [63:0] ua, ub;
      logic [127:0] p;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (neg) begin
         if (p > 128'(SAT_HI) + 1) return SAT_LO;
         return -longint'(p[63:0]);
      end
      if (p > 128'(SAT_HI)) return SAT_HI;
      return longint'(p[63:0]);
   endfunction

   task automatic heading_sincos(input longint heading, output longint c, output longint s);
      logic [63:0] prod;
      logic [31:0] ph;
      bit flip;
      longint x, y, z, tx, ty;
      prod = heading * 64'd683565276;
      ph = prod[63:32];
      flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
      if (flip) ph = ph - 32'h80000000;
      z = longint'($signed(ph));
      x = 652032875;
      y = 0;
      for (int i = 0; i < 24; i++) begin
         tx = y >>> i;
         ty = x >>> i;
         if (z >= 0) begin
            x = x - tx; y = y + ty; z = z - longint'(ATAN_TURNS[i]);
         end else begin
            x = x + tx; y = y - ty; z = z + longint'(ATAN_TURNS[i]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic propagate_motion(input longint dl, input longint dr);
      longint ld, rd, d, c, s, dx, dy, fa, fb, cc, cs, ss;
      longint a [9];
      longint m [9];
      ld = clip48(dl * longint'(gain_mpt));
      rd = clip48(dr * longint'(gain_mpt));
      d = (ld + rd) / 2;
      heading_sincos(pose_m[2], c, s);
      dx = mul_round(d, c, 30);
      dy = mul_round(d, s, 30);
      pose_m[0] = clip48(pose_m[0] + dx);
      pose_m[1] = clip48(pose_m[1] + dy);
      pose_m[2] = clip48(pose_m[2] + mul_round(rd - ld, longint'(gain_track), 16));
      fa = clip48(-dy);
      fb = dx;
      for (int i = 0; i < 3; i++) begin
         a[i] = clip48(cov_m[i] + mul_round(fa, cov_m[6 + i], 32));
         a[3 + i] = clip48(cov_m[3 + i] + mul_round(fb, cov_m[6 + i], 32));
         a[6 + i] = cov_m[6 + i];
      end
      for (int i = 0; i < 3; i++) begin
         m[3 * i] = clip48(a[3 * i] + mul_round(fa, a[3 * i + 2], 32));
         m[3 * i + 1] = clip48(a[3 * i + 1] + mul_round(fb, a[3 * i + 2], 32));
         m[3 * i + 2] = a[3 * i + 2];
      end
      cc = mul_round(mul_round(c, c, 30), longint'(var_dist), 30);
      cs = mul_round(mul_round(c, s, 30), longint'(var_dist), 30);
      ss = mul_round(mul_round(s, s, 30), longint'(var_dist), 30);
      m[0] = clip48(m[0] + cc);
      m[1] = clip48(m[1] + cs);
      m[3] = clip48(m[3] + cs);
      m[4] = clip48(m[4] + ss);
      m[8] = clip48(m[8] + longint'(var_head));
      cov_m = m;
   endtask

   // advances the predictor by one accepted word; returns 1 if a state word comes back
   task automatic ekf_step(input row_type w, output bit emits, output state_snap_type snap);
      emits = 0;
      snap = '0;
      if (w.func) begin
         if (w.idx < 3) pose_m[w.idx] = longint'($signed(w.value));
         else if (w.idx < 12) cov_m[w.idx - 3] = longint'($signed(w.value));
         return;
      end
      if (!primed) begin
         primed = 1;
         last_left = w.left;
         last_right = w.right;
         return;
      end
      if (w.left != last_left || w.right != last_right)
         propagate_motion(longint'($signed(w.left - last_left)),
                          longint'($signed(w.right - last_right)));
      last_left = w.left;
      last_right = w.right;
      for (int i = 0; i < 3; i++) snap[i] = pose_m[i][47:0];
      for (int i = 0; i < 9; i++) snap[3 + i] = cov_m[i][47:0];
      emits = 1;
   endtask

   // receiver: random stalls plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      state_snap_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_cov_22, rsp_cov_21, rsp_cov_20, rsp_cov_12, rsp_cov_11, rsp_cov_10,
                rsp_cov_02, rsp_cov_01, rsp_cov_00, rsp_pose_heading, rsp_pose_y, rsp_pose_x};
         if (pending_states.size() == 0) begin
            errors++;
            $display("%0t: state word with nothing expected", $time);
         end else begin
            want = pending_states.pop_front();
            states_checked++;
            for (int i = 0; i < 12; i++) begin
               if (got[i] !== want[i]) begin
                  errors++;
                  $display("%0t: %s expected %h actual %h", $time, field_names[i],
                           want[i], got[i]);
               end
            end
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         CSR_DIST_PER_TICK:     gain_mpt = data;
         CSR_INV_TRACK:         gain_track = data;
         CSR_DISTANCE_VARIANCE: var_dist = data;
         CSR_HEADING_VARIANCE:  var_head = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // block must be idle before a register write; loads and priming words give no result
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_word(input row_type w);
      bit emits;
      state_snap_type snap;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = w.func;
      req_left_ticks = w.left;
      req_right_ticks = w.right;
      req_load_index = w.idx;
      req_load_value = w.value;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      ekf_step(w, emits, snap);
      if (emits) pending_states.push_back(w.zero_state ? state_snap_type'('0) : snap);
      words_sent++;
      @(negedge clock);
   endtask

   function automatic row_type enc_row(logic [31:0] l, logic [31:0] r, bit zs = 0);
      row_type w;
      w = '{kind: ROW_WORD, func: 1'b0, left: l, right: r, idx: '0, value: '0,
            reg_idx: '0, reg_data: '0, zero_state: zs};
      return w;
   endfunction

   function automatic row_type load_row(logic [3:0] i, logic [47:0] v);
      row_type w;
      w = enc_row($urandom, $urandom);
      w.func = 1'b1;
      w.idx = i;
      w.value = v;
      return w;
   endfunction

   function automatic row_type reg_row(logic [CSR_IDX_W-1:0] i, logic [31:0] d);
      row_type w;
      w = enc_row(0, 0);
      w.kind = ROW_CSR;
      w.reg_idx = i;
      w.reg_data = d;
      return w;
   endfunction

   initial begin
      row_type plan[$];
      row_type w;
      logic [31:0] cur_l, cur_r;
      logic [31:0] cfg [4];
      int r, mode;
      bit in_regs;

      gain_mpt = 0; gain_track = 0; var_dist = 0; var_head = 0;
      foreach (pose_m[i]) pose_m[i] = 0;
      foreach (cov_m[i]) cov_m[i] = 0;
      last_left = 0; last_right = 0; primed = 0;

      // directed table
      plan.push_back(enc_row(5, 7));                       // priming pair, silent
      plan.push_back(enc_row(5, 7, 1));                    // unchanged counts
      plan.push_back(enc_row(105, -93, 1));                // all gains zero after reset
      plan.push_back(load_row(4'd12, 48'h7FFF_FFFF_FFFF)); // ignored index
      plan.push_back(load_row(4'd15, 48'h8000_0000_0000));
      plan.push_back(enc_row(105, -93, 1));
      plan.push_back(reg_row(CSR_DIST_PER_TICK, 32'hFFFF_FFFF));
      plan.push_back(reg_row(CSR_INV_TRACK, 32'hFFFF_FFFF));
      plan.push_back(reg_row(CSR_DISTANCE_VARIANCE, 32'hFFFF_FFFF));
      plan.push_back(reg_row(CSR_HEADING_VARIANCE, 32'hFFFF_FFFF));
      plan.push_back(reg_row(8'd200, 32'h1234_5678));      // unmapped register
      plan.push_back(enc_row(32'h7FFF_FFFF, 32'h8000_0000));
      plan.push_back(enc_row(32'h8000_0000, 32'h7FFF_FFFF));
      plan.push_back(load_row(4'd0, 48'h7FFF_FFFF_FFFF));
      plan.push_back(load_row(4'd1, 48'h8000_0000_0000));
      plan.push_back(load_row(4'd2, 48'h7FFF_FFFF_FFFF));
      plan.push_back(load_row(4'd3, 48'h8000_0000_0000));
      plan.push_back(load_row(4'd7, 48'hFFFF_FFFF_FFFF));
      plan.push_back(load_row(4'd11, 48'h7FFF_FFFF_FFFF));
      plan.push_back(enc_row(32'h8000_0000, 32'h7FFF_FFFF));
      plan.push_back(enc_row(32'h8000_0001, 32'h7FFF_FFFF));
      plan.push_back(reg_row(CSR_DIST_PER_TICK, 32'h0010_0000));
      plan.push_back(reg_row(CSR_INV_TRACK, 32'h000A_0000));
      plan.push_back(reg_row(CSR_DISTANCE_VARIANCE, 32'h0001_0000));
      plan.push_back(reg_row(CSR_HEADING_VARIANCE, 32'h0000_0100));
      plan.push_back(load_row(4'd2, 48'h0001_8000_0000));  // heading 1.5 rad
      plan.push_back(enc_row(32'h8000_0101, 32'h7FFF_FF80));
      plan.push_back(load_row(4'd2, 48'h0003_0000_0000));  // near pi
      plan.push_back(enc_row(32'h8000_0001, 32'h8000_0001));
      plan.push_back(load_row(4'd2, 48'hFFFE_0000_0000));  // -2 rad
      plan.push_back(enc_row(32'h8000_0401, 32'h8000_0301));
      plan.push_back(enc_row(32'h0000_0000, 32'hFFFF_FFFF));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      in_regs = 1;
      foreach (plan[k]) begin
         if (plan[k].kind == ROW_CSR) begin
            if (!in_regs) wait_idle();
            in_regs = 1;
            write_reg(plan[k].reg_idx, plan[k].reg_data);
         end else begin
            in_regs = 0;
            send_word(plan[k]);
         end
      end

      cur_l = 32'h0000_0000;
      cur_r = 32'hFFFF_FFFF;
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         case (p)
            1: cfg = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            3: cfg = '{32'h0, 32'h0, 32'h0, 32'h0};
            2, 4: cfg = '{$urandom, $urandom, $urandom, $urandom};
            default: cfg = '{$urandom_range(32'h0040_0000), $urandom_range(32'h0020_0000),
                             $urandom_range(32'h0100_0000), $urandom_range(32'h0001_0000)};
         endcase
         for (int i = 0; i < 4; i++) write_reg(i[CSR_IDX_W-1:0], cfg[i]);
         if ($urandom_range(1)) write_reg(CSR_IDX_W'($urandom_range(255, 4)), $urandom);
         mode = p % 3;
         tx_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 57 : 0;
         rx_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 26 : 0;
         if (p == 2) hold_request = 3000;   // sender keeps offering until input backs up
         for (int n = 0; n < 125; n++) begin
            r = $urandom_range(99);
            if (r < 15) begin
               w = load_row(4'($urandom_range(15)),
                            $urandom_range(1) ? 48'({$urandom, $urandom}) :
                            48'($signed({$urandom_range(3), $urandom})) - 48'h2_0000_0000);
            end else begin
               if (r < 20) begin
                  // same counts
               end else if (r < 27) begin
                  cur_l = $urandom;
                  cur_r = $urandom;
               end else begin
                  cur_l = cur_l + $urandom_range(2000) - 1000;
                  cur_r = cur_r + $urandom_range(2000) - 1000;
               end
               w = enc_row(cur_l, cur_r);
            end
            send_word(w);
         end
      end

      req_valid = 1'b0;
      while (pending_states.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d words over the directed table and 6 register settings.", words_sent);
      $display("Checked %0d returned states, stall patterns and a long output hold-off.",
               states_checked);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d states still expected", pending_states.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
